@@ rtl/core/wes_pkg.sv @@
// Package for the wave equation stencil block: payload, job and control types,
// register codes, reset values and sizing constants. Depends on nothing.
`timescale 1ns / 1ps

package wes_pkg;

   // Sizing defaults for the top-level parameters.
   localparam int MAX_POINTS_DEFAULT = 4096;
   localparam int FRAC_BITS_DEFAULT  = 16;

   // Fixed widths of the item fields and of the internal differences.
   localparam int DATA_W   = 32;
   localparam int KREG_W   = 31;
   localparam int MODE_W   = 6;
   localparam int INDEX_W  = 12;
   localparam int DIFF_W   = 35;
   localparam int WIDE_W   = 128;
   localparam int OPB_W    = 64;
   localparam int CSR_IDX_W = 3;

   // Depth of the job queue between front and back.
   localparam int QUEUE_DEPTH = 2;

   // Cap on the potential magnitudes.
   localparam logic [63:0] MAG_CAP = 64'h4000_0000_0000_0000;

   // Register reset values.
   localparam logic [KREG_W-1:0] INV_SPACING_RST     = 31'd197263;
   localparam logic [KREG_W-1:0] INV_SPACING_SQ_RST  = 31'd593763;
   localparam logic [KREG_W-1:0] INV_TWO_SPACING_RST = 31'd98632;
   localparam logic [MODE_W-1:0] HARMONIC_MODE_RST   = 6'd1;
   localparam logic [KREG_W-1:0] HOLE_MASS_RST       = 31'd65536;

   // Register index codes.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_INV_SPACING     = 3'd0,
      CSR_INV_SPACING_SQ  = 3'd1,
      CSR_INV_TWO_SPACING = 3'd2,
      CSR_HARMONIC_MODE   = 3'd3,
      CSR_HOLE_MASS       = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] field_value;
      logic signed [DATA_W-1:0] field_gradient;
      logic signed [DATA_W-1:0] field_momentum;
      logic        [KREG_W-1:0] radius;
      logic                     last_point;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0]  value_rate;
      logic signed [DATA_W-1:0]  gradient_rate;
      logic signed [DATA_W-1:0]  momentum_rate;
      logic        [INDEX_W-1:0] point_index;
      logic                      final_point;
   } rsp_type;

   typedef struct packed {
      logic [KREG_W-1:0] inv_spacing;
      logic [KREG_W-1:0] inv_spacing_sq;
      logic [KREG_W-1:0] inv_two_spacing;
      logic [MODE_W-1:0] harmonic_mode;
      logic [KREG_W-1:0] hole_mass;
   } cfg_type;

   // One result to compute: gradient = scale(grad_diff, grad_k),
   // momentum = scale(mom_diff, mom_k) - V(radius) * phi.
   typedef struct packed {
      logic signed [DATA_W-1:0]  rate;
      logic signed [DIFF_W-1:0]  grad_diff;
      logic        [KREG_W-1:0]  grad_k;
      logic signed [DIFF_W-1:0]  mom_diff;
      logic        [KREG_W-1:0]  mom_k;
      logic        [KREG_W-1:0]  radius;
      logic signed [DATA_W-1:0]  phi;
      logic        [INDEX_W-1:0] index;
      logic                      final_point;
   } job_type;

   typedef struct packed {
      logic              start;
      logic              is_div;
      logic [WIDE_W-1:0] a;
      logic [OPB_W-1:0]  b;
   } mdu_req_type;

   typedef struct packed {
      logic              busy;
      logic              done;
      logic [WIDE_W-1:0] result;
   } mdu_rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_GRAD,
      ST_MOM,
      ST_U,
      ST_T2,
      ST_P,
      ST_X,
      ST_Q,
      ST_T,
      ST_DONE
   } back_state_type;

endpackage

@@ rtl/core/wes_front.sv @@
// Front end: accepts grid points, keeps the two-point window and the point
// counter, and turns each point into zero, one or two jobs. Uses wes_pkg.
`timescale 1ns / 1ps

module wes_front
   import wes_pkg::*;
#(
   parameter int MAX_POINTS = MAX_POINTS_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   input  cfg_type cfg,
   output logic    push_valid,
   input  logic    push_ready,
   output job_type push_data
);

   localparam int CNT_W = $clog2(MAX_POINTS);

   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic signed [DATA_W-1:0] wv_ff [2];
   logic signed [DATA_W-1:0] wg_ff [2];
   logic signed [DATA_W-1:0] wm_ff [2];
   logic [KREG_W-1:0]        wr_ff [2];
   job_type                  job_a_ff, job_b_ff, job_a_in, job_b_in;
   logic                     have_a_ff, have_b_ff, have_a_in, have_b_in;

   logic                     accept, last;
   logic signed [DIFF_W-1:0] d_m_far, d_m_near, d_g_near, d_2;

   assign accept    = req_valid && req_ready;
   assign req_ready = !have_a_ff && !have_b_ff;
   assign last      = req_data.last_point || (cnt_ff >= CNT_W'(MAX_POINTS - 1));

   // Exact differences over the window.
   assign d_m_far  = DIFF_W'(req_data.field_momentum) - DIFF_W'(wm_ff[0]);
   assign d_m_near = DIFF_W'(req_data.field_momentum) - DIFF_W'(wm_ff[1]);
   assign d_g_near = DIFF_W'(req_data.field_gradient) - DIFF_W'(wg_ff[1]);
   assign d_2      = DIFF_W'(req_data.field_value) - (DIFF_W'(wv_ff[1]) <<< 1)
                     + DIFF_W'(wv_ff[0]);

   // Classify the point and build its jobs.
   always_comb begin
      job_a_in  = job_a_ff;
      job_b_in  = job_b_ff;
      have_a_in = have_a_ff;
      have_b_in = have_b_ff;
      cnt_in    = cnt_ff;

      // The outermost point, seen from this point as the right edge.
      job_b_in.rate        = req_data.field_momentum;
      job_b_in.grad_diff   = d_m_near;
      job_b_in.grad_k      = cfg.inv_spacing;
      job_b_in.mom_diff    = d_g_near;
      job_b_in.mom_k       = cfg.inv_spacing;
      job_b_in.radius      = req_data.radius;
      job_b_in.phi         = req_data.field_value;
      job_b_in.index       = INDEX_W'(cnt_ff);
      job_b_in.final_point = 1'b1;

      // The previous point.
      job_a_in.rate        = wm_ff[1];
      job_a_in.radius      = wr_ff[1];
      job_a_in.phi         = wv_ff[1];
      job_a_in.index       = INDEX_W'(cnt_ff - CNT_W'(1));
      job_a_in.final_point = 1'b0;
      if (cnt_ff == CNT_W'(1)) begin
         job_a_in.grad_diff = d_m_near;
         job_a_in.grad_k    = cfg.inv_spacing;
         job_a_in.mom_diff  = d_g_near;
         job_a_in.mom_k     = cfg.inv_spacing;
      end else begin
         job_a_in.grad_diff = d_m_far;
         job_a_in.grad_k    = cfg.inv_two_spacing;
         job_a_in.mom_diff  = d_2;
         job_a_in.mom_k     = cfg.inv_spacing_sq;
      end

      if (accept) begin
         if (cnt_ff == '0) begin
            // A grid of a single point has no differences at all.
            have_a_in          = 1'b0;
            have_b_in          = last;
            job_b_in.grad_diff = '0;
            job_b_in.mom_diff  = '0;
         end else begin
            have_a_in = 1'b1;
            have_b_in = last;
         end
         cnt_in = last ? '0 : cnt_ff + CNT_W'(1);
      end else if (push_valid && push_ready) begin
         if (have_a_ff) begin
            have_a_in = 1'b0;
         end else begin
            have_b_in = 1'b0;
         end
      end
   end

   assign push_valid = have_a_ff || have_b_ff;
   assign push_data  = have_a_ff ? job_a_ff : job_b_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff    <= '0;
         have_a_ff <= 1'b0;
         have_b_ff <= 1'b0;
      end else begin
         cnt_ff    <= cnt_in;
         have_a_ff <= have_a_in;
         have_b_ff <= have_b_in;
      end
   end

   // The jobs are captured with the item and held until pushed.
   // Window shift; the window is left as is at the end of a sweep.
   always_ff @(posedge clock) begin
      if (accept) begin
         job_a_ff <= job_a_in;
         job_b_ff <= job_b_in;
      end
      if (accept && !last) begin
         wv_ff[0] <= wv_ff[1];
         wg_ff[0] <= wg_ff[1];
         wm_ff[0] <= wm_ff[1];
         wr_ff[0] <= wr_ff[1];
         wv_ff[1] <= req_data.field_value;
         wg_ff[1] <= req_data.field_gradient;
         wm_ff[1] <= req_data.field_momentum;
         wr_ff[1] <= req_data.radius;
      end
   end

endmodule

@@ rtl/core/wes_queue.sv @@
// Small job queue between the front end and the arithmetic back end.
// Uses the job type and depth from wes_pkg.
`timescale 1ns / 1ps

module wes_queue
   import wes_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_ready,
   input  job_type push_data,
   output logic    pop_valid,
   input  logic    pop,
   output job_type pop_data
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   job_type          mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [PTR_W:0]   count_ff;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != (PTR_W + 1)'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   // Pointers wrap at the depth, which need not be a power of two.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
         end
         count_ff <= count_ff + (PTR_W + 1)'(do_push) - (PTR_W + 1)'(do_pop);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ rtl/core/wes_mdu.sv @@
// Iterative multiply and divide unit: shift-add multiply of a 128-bit operand
// by a 64-bit operand, restoring divide of 128 bits by 32. Uses wes_pkg.
`timescale 1ns / 1ps

module wes_mdu
   import wes_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  mdu_req_type mreq,
   output mdu_rsp_type mrsp
);

   localparam int CNT_W = $clog2(WIDE_W);

   logic              busy_ff, done_ff, is_div_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic [WIDE_W-1:0] opa_ff, opa_in, acc_ff, acc_in;
   logic [OPB_W-1:0]  opb_ff, opb_in;
   logic [31:0]       rem_ff, rem_in;
   logic [32:0]       trial;
   logic              fits;

   // One bit of the quotient or of the multiplier each cycle.
   always_comb begin
      trial  = {rem_ff, opa_ff[WIDE_W-1]};
      fits   = (trial >= {1'b0, opb_ff[31:0]});
      rem_in = rem_ff;
      acc_in = acc_ff;
      opb_in = opb_ff;
      if (is_div_ff) begin
         rem_in = fits ? 32'(trial - {1'b0, opb_ff[31:0]}) : trial[31:0];
         opa_in = {opa_ff[WIDE_W-2:0], fits};
      end else begin
         acc_in = opb_ff[0] ? acc_ff + opa_ff : acc_ff;
         opa_in = {opa_ff[WIDE_W-2:0], 1'b0};
         opb_in = {1'b0, opb_ff[OPB_W-1:1]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (mreq.start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && cnt_ff == '0) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mreq.start) begin
         is_div_ff <= mreq.is_div;
         opa_ff    <= mreq.a;
         opb_ff    <= mreq.b;
         acc_ff    <= '0;
         rem_ff    <= '0;
         cnt_ff    <= mreq.is_div ? CNT_W'(WIDE_W - 1) : CNT_W'(OPB_W - 1);
      end else if (busy_ff) begin
         opa_ff <= opa_in;
         opb_ff <= opb_in;
         acc_ff <= acc_in;
         rem_ff <= rem_in;
         cnt_ff <= cnt_ff - CNT_W'(1);
      end
   end

   assign mrsp.busy   = busy_ff;
   assign mrsp.done   = done_ff;
   assign mrsp.result = is_div_ff ? opa_ff : acc_ff;

   a_start_idle : assert property (@(posedge clock) disable iff (reset)
      mreq.start |-> !busy_ff)
      else $error("multiply/divide started while busy");

   a_done_pulse : assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff)
      else $error("done raised while still iterating");

   a_done_after : assert property (@(posedge clock) disable iff (reset)
      (busy_ff && cnt_ff == '0 && !mreq.start) |=> done_ff)
      else $error("last step did not raise done");

endmodule

@@ rtl/core/wes_back.sv @@
// Back end: takes jobs from the queue, runs the scaled differences and the
// potential term through wes_mdu, saturates and holds the result. Uses wes_pkg.
`timescale 1ns / 1ps

module wes_back
   import wes_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        pop_valid,
   output logic        pop,
   input  job_type     pop_data,
   output mdu_req_type mreq,
   input  mdu_rsp_type mrsp,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data
);

   back_state_type    state_ff, state_in;
   job_type           job_ff;
   logic              issued_ff, pot_zero_ff, rsp_valid_ff, rsp_load;
   rsp_type           rsp_data_ff;
   logic signed [63:0] grad_ff, mom_ff, mom_total, scaled;
   logic [63:0]       u_ff, w_ff, v_ff, potmag_ff, shifted, capped;
   logic [WIDE_W-1:0] x_ff;

   logic [31:0]        rs, m2, amag, pm;
   logic               neg_r, pneg;
   logic [11:0]        ll;
   logic [DIFF_W-1:0]  gmag, mmag;

   function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] v);
      logic signed [63:0] hi, lo;
      hi = 64'sh0000_0000_7FFF_FFFF;
      lo = -64'sh0000_0000_8000_0000;
      if (v > hi) begin
         return DATA_W'(hi);
      end else if (v < lo) begin
         return DATA_W'(lo);
      end
      return DATA_W'(v);
   endfunction

   // Operands of the current job.
   assign rs    = (job_ff.radius == '0) ? 32'd1 : {1'b0, job_ff.radius};
   assign m2    = {cfg.hole_mass, 1'b0};
   assign neg_r = (m2 > rs);
   assign amag  = neg_r ? m2 - rs : rs - m2;
   assign ll    = 12'(cfg.harmonic_mode * (7'(cfg.harmonic_mode) + 7'd1));
   assign pm    = 32'(job_ff.phi[DATA_W-1] ? -33'(job_ff.phi) : 33'(job_ff.phi));
   assign pneg  = neg_r ^ job_ff.phi[DATA_W-1];
   assign gmag  = job_ff.grad_diff[DIFF_W-1] ? DIFF_W'(-job_ff.grad_diff) : job_ff.grad_diff;
   assign mmag  = job_ff.mom_diff[DIFF_W-1] ? DIFF_W'(-job_ff.mom_diff) : job_ff.mom_diff;

   // Shifted product and its capped form (in ST_Q, of the unshifted quotient), shared by the capture steps.
   assign shifted = 64'(mrsp.result >> FRAC_BITS);
   assign scaled  = (state_ff == ST_GRAD) ?
                    (job_ff.grad_diff[DIFF_W-1] ? -$signed(shifted) : $signed(shifted)) :
                    (job_ff.mom_diff[DIFF_W-1] ? -$signed(shifted) : $signed(shifted));
   assign capped  = (state_ff == ST_Q) ?
                    ((mrsp.result[WIDE_W-1:64] != '0 || mrsp.result[63:0] > MAG_CAP) ?
                     MAG_CAP : mrsp.result[63:0]) :
                    ((64'(mrsp.result >> (FRAC_BITS + 64)) != '0 || shifted > MAG_CAP) ?
                     MAG_CAP : shifted);

   assign mom_total = pneg ? mom_ff + $signed(potmag_ff) : mom_ff - $signed(potmag_ff);

   // Sequencer over the multiply and divide steps of one job.
   always_comb begin
      state_in   = state_ff;
      pop        = 1'b0;
      rsp_load   = 1'b0;
      mreq       = '0;
      mreq.start = !issued_ff;
      unique case (state_ff)
         ST_IDLE: begin
            mreq.start = 1'b0;
            if (pop_valid) begin
               pop      = 1'b1;
               state_in = ST_GRAD;
            end
         end
         ST_GRAD: begin
            mreq.a = WIDE_W'(gmag);
            mreq.b = OPB_W'(job_ff.grad_k);
            if (mrsp.done) state_in = ST_MOM;
         end
         ST_MOM: begin
            mreq.a = WIDE_W'(mmag);
            mreq.b = OPB_W'(job_ff.mom_k);
            if (mrsp.done) state_in = pot_zero_ff ? ST_DONE : ST_U;
         end
         ST_U: begin
            mreq.is_div = 1'b1;
            mreq.a      = WIDE_W'(amag) << FRAC_BITS;
            mreq.b      = OPB_W'(rs);
            if (mrsp.done) state_in = ST_T2;
         end
         ST_T2: begin
            mreq.is_div = 1'b1;
            mreq.a      = WIDE_W'(m2) << FRAC_BITS;
            mreq.b      = OPB_W'(rs);
            if (mrsp.done) state_in = ST_P;
         end
         ST_P: begin
            mreq.a = WIDE_W'(u_ff);
            mreq.b = w_ff;
            if (mrsp.done) state_in = ST_X;
         end
         ST_X: begin
            mreq.is_div = 1'b1;
            mreq.a      = x_ff;
            mreq.b      = OPB_W'(rs);
            if (mrsp.done) state_in = (mrsp.result[WIDE_W-1:96] != '0) ? ST_T : ST_Q;
         end
         ST_Q: begin
            mreq.is_div = 1'b1;
            mreq.a      = x_ff << FRAC_BITS;
            mreq.b      = OPB_W'(rs);
            if (mrsp.done) state_in = ST_T;
         end
         ST_T: begin
            mreq.a = WIDE_W'(v_ff);
            mreq.b = OPB_W'(pm);
            if (mrsp.done) state_in = ST_DONE;
         end
         ST_DONE: begin
            mreq.start = 1'b0;
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            mreq.start = 1'b0;
            state_in   = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         issued_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (mreq.start) begin
            issued_ff <= 1'b1;
         end else if (mrsp.done) begin
            issued_ff <= 1'b0;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Captures of the intermediate values as each step finishes.
   always_ff @(posedge clock) begin
      if (pop) begin
         job_ff      <= pop_data;
         potmag_ff   <= '0;
         pot_zero_ff <= (pop_data.phi == '0) ||
                        (pop_data.radius == '0 ? (m2 == 32'd1) : (m2 == {1'b0, pop_data.radius}));
      end
      if (mrsp.done) begin
         case (state_ff)
            ST_GRAD: grad_ff <= scaled;
            ST_MOM:  mom_ff  <= scaled;
            ST_U:    u_ff    <= mrsp.result[63:0];
            ST_T2:   w_ff    <= (64'(ll) << FRAC_BITS) + mrsp.result[63:0];
            ST_P:    x_ff    <= mrsp.result;
            ST_X: begin
               x_ff <= mrsp.result;
               if (mrsp.result[WIDE_W-1:96] != '0) v_ff <= MAG_CAP;
            end
            ST_Q:    v_ff      <= capped;
            ST_T:    potmag_ff <= capped;
            default: begin
            end
         endcase
      end
      if (rsp_load) begin
         rsp_data_ff.value_rate    <= job_ff.rate;
         rsp_data_ff.gradient_rate <= sat32(grad_ff);
         rsp_data_ff.momentum_rate <= sat32(mom_total);
         rsp_data_ff.point_index   <= job_ff.index;
         rsp_data_ff.final_point   <= job_ff.final_point;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_load_free : assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("result overwritten before it was taken");

   a_x_cap : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_X && mrsp.done && mrsp.result[WIDE_W-1:96] != '0) |=>
         (v_ff == MAG_CAP && state_ff == ST_T))
      else $error("oversized quotient not capped");

   a_no_issue_idle : assert property (@(posedge clock) disable iff (reset)
      mreq.start |-> (state_ff != ST_IDLE && state_ff != ST_DONE))
      else $error("arithmetic started outside a compute step");

endmodule

@@ rtl/core/wave_equation_stencil_rhs_top.sv @@
// Top level of the wave equation stencil block: register file and the front,
// queue, multiply/divide and back instances. Uses wes_pkg and all wes_ modules.
`timescale 1ns / 1ps

// Grid points enter one per item on req_; each gives the time derivatives of
// the previous point on rsp_ once its right neighbor is known, and the last
// point of a sweep of two or more points gives two results. The rates are
// worked out by one shared iterative multiply/divide unit, one bit per cycle.
// A result whose potential term is zero needs only the two scaling
// multiplies; any other also needs four divides (three if the third one
// overflows) and two multiplies for the potential. A point waits at the input
// only while its own jobs are moved into the two-entry job queue, so the
// sustained rate is set by the arithmetic unit. Registers are to be written
// on csr_ only while the block is idle; the block does not enforce this.
module wave_equation_stencil_rhs_top
   import wes_pkg::*;
#(
   parameter int MAX_POINTS = MAX_POINTS_DEFAULT,
   parameter int FRAC_BITS  = FRAC_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_type              rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DATA_W-1:0]    csr_data
);

   cfg_type     cfg_ff;
   logic        push_valid, push_ready, pop_valid, pop;
   job_type     push_data, pop_data;
   mdu_req_type mreq;
   mdu_rsp_type mrsp;

   assign csr_ready = 1'b1;

   // Register file; unknown indexes are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.inv_spacing     <= INV_SPACING_RST;
         cfg_ff.inv_spacing_sq  <= INV_SPACING_SQ_RST;
         cfg_ff.inv_two_spacing <= INV_TWO_SPACING_RST;
         cfg_ff.harmonic_mode   <= HARMONIC_MODE_RST;
         cfg_ff.hole_mass       <= HOLE_MASS_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_INV_SPACING:     cfg_ff.inv_spacing     <= csr_data[KREG_W-1:0];
            CSR_INV_SPACING_SQ:  cfg_ff.inv_spacing_sq  <= csr_data[KREG_W-1:0];
            CSR_INV_TWO_SPACING: cfg_ff.inv_two_spacing <= csr_data[KREG_W-1:0];
            CSR_HARMONIC_MODE:   cfg_ff.harmonic_mode   <= csr_data[MODE_W-1:0];
            CSR_HOLE_MASS:       cfg_ff.hole_mass       <= csr_data[KREG_W-1:0];
            default: begin
            end
         endcase
      end
   end

   wes_front #(.MAX_POINTS(MAX_POINTS)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .cfg        (cfg_ff),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   wes_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop        (pop),
      .pop_data   (pop_data)
   );

   wes_mdu u_mdu (
      .clock (clock),
      .reset (reset),
      .mreq  (mreq),
      .mrsp  (mrsp)
   );

   wes_back #(.FRAC_BITS(FRAC_BITS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .pop_valid (pop_valid),
      .pop       (pop),
      .pop_data  (pop_data),
      .mreq      (mreq),
      .mrsp      (mrsp),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

@@ dv/wave_equation_stencil_rhs_top_tb.sv @@
// Self-checking testbench for wave_equation_stencil_rhs_top: drives grid point
// sweeps and register writes, predicts every rate result and compares it.
// Depends on wes_pkg and the wave_equation_stencil_rhs_top RTL.
`timescale 1ns / 1ps

module wave_equation_stencil_rhs_top_tb;
   import wes_pkg::*;

   localparam int FRAC         = FRAC_BITS_DEFAULT;
   localparam int POINTS_LIMIT = MAX_POINTS_DEFAULT;
   localparam int SETTLE_CYCLES = 1000;
   localparam int STALL_LIMIT   = 40000;

   // Predicts the rates of each grid point and holds them until they come out.
   class rate_scoreboard;
      logic [KREG_W-1:0] inv_h, inv_h_sq, inv_2h, mass;
      logic [MODE_W-1:0] mode;
      logic signed [DATA_W-1:0] win_phi[2], win_phix[2], win_pi[2];
      logic [KREG_W-1:0] win_r[2];
      int unsigned sweep_pos;
      rsp_type expected_rates[$];
      int errors;

      function void clear();
         inv_h = INV_SPACING_RST;
         inv_h_sq = INV_SPACING_SQ_RST;
         inv_2h = INV_TWO_SPACING_RST;
         mode = HARMONIC_MODE_RST;
         mass = HOLE_MASS_RST;
         for (int i = 0; i < 2; i++) begin
            win_phi[i] = 0; win_phix[i] = 0; win_pi[i] = 0; win_r[i] = 0;
         end
         sweep_pos = 0;
         expected_rates.delete();
         errors = 0;
      endfunction

      function void write_reg(csr_index_type idx, logic [DATA_W-1:0] data);
         case (idx)
            CSR_INV_SPACING:     inv_h = data[KREG_W-1:0];
            CSR_INV_SPACING_SQ:  inv_h_sq = data[KREG_W-1:0];
            CSR_INV_TWO_SPACING: inv_2h = data[KREG_W-1:0];
            CSR_HARMONIC_MODE:   mode = data[MODE_W-1:0];
            CSR_HOLE_MASS:       mass = data[KREG_W-1:0];
            default: ;
         endcase
      endfunction

      // Difference times an unsigned Q register, truncated toward zero.
      function longint scale_by(longint d, logic [KREG_W-1:0] k);
         logic [63:0] mag;
         logic [127:0] p;
         mag = (d < 0) ? -d : d;
         p = ({64'd0, mag} * {97'd0, k}) >> FRAC;
         return (d < 0) ? -longint'(p[63:0]) : longint'(p[63:0]);
      endfunction

      // Potential times phi, magnitude capped.
      function longint potential_of(logic [KREG_W-1:0] radius, logic signed [DATA_W-1:0] phi);
         logic [127:0] rs, m2, lsq, amag, u, w, x, q, t, v, pm;
         bit neg;
         rs = (radius == 0) ? 128'd1 : {97'd0, radius};
         m2 = {96'd0, mass, 1'b0};
         lsq = mode * (mode + 1);
         neg = m2 > rs;
         amag = neg ? m2 - rs : rs - m2;
         if (amag == 0 || phi == 0) return 0;
         u = (amag << FRAC) / rs;
         w = (lsq << FRAC) + ((m2 << FRAC) / rs);
         x = (u * w) / rs;
         if (x[127:96] != 0) v = {64'd0, MAG_CAP};
         else begin
            q = (x << FRAC) / rs;
            v = (q > {64'd0, MAG_CAP}) ? {64'd0, MAG_CAP} : q;
         end
         pm = (phi < 0) ? 128'(-longint'(phi)) : 128'(longint'(phi));
         t = (v * pm) >> FRAC;
         v = (t > {64'd0, MAG_CAP}) ? {64'd0, MAG_CAP} : t;
         if (phi < 0) neg = !neg;
         return neg ? -longint'(v[63:0]) : longint'(v[63:0]);
      endfunction

      function logic signed [DATA_W-1:0] sat32(longint v);
         if (v > 64'sd2147483647) return 32'sh7fffffff;
         if (v < -64'sd2147483648) return 32'sh80000000;
         return v[31:0];
      endfunction

      function void push_rate(logic signed [DATA_W-1:0] rate, longint grad, longint mom,
                              int unsigned idx, bit fin);
         rsp_type r;
         r.value_rate = rate;
         r.gradient_rate = sat32(grad);
         r.momentum_rate = sat32(mom);
         r.point_index = idx[INDEX_W-1:0];
         r.final_point = fin;
         expected_rates.push_back(r);
      endfunction

      // Works out the rates that an accepted grid point releases.
      function void note_point(req_type p);
         longint grad, mom, d2;
         int unsigned idx;
         bit last;
         idx = sweep_pos;
         last = p.last_point || idx >= POINTS_LIMIT - 1;
         if (idx == 0) begin
            if (last) push_rate(p.field_momentum, 0,
                                -potential_of(p.radius, p.field_value), 0, 1);
         end else if (idx == 1) begin
            grad = scale_by(longint'(p.field_momentum) - win_pi[1], inv_h);
            mom = scale_by(longint'(p.field_gradient) - win_phix[1], inv_h);
            push_rate(win_pi[1], grad, mom - potential_of(win_r[1], win_phi[1]), 0, 0);
            if (last) push_rate(p.field_momentum, grad,
                                mom - potential_of(p.radius, p.field_value), 1, 1);
         end else begin
            d2 = longint'(p.field_value) - 2 * longint'(win_phi[1]) + win_phi[0];
            grad = scale_by(longint'(p.field_momentum) - win_pi[0], inv_2h);
            mom = scale_by(d2, inv_h_sq) - potential_of(win_r[1], win_phi[1]);
            push_rate(win_pi[1], grad, mom, idx - 1, 0);
            if (last) begin
               grad = scale_by(longint'(p.field_momentum) - win_pi[1], inv_h);
               mom = scale_by(longint'(p.field_gradient) - win_phix[1], inv_h)
                     - potential_of(p.radius, p.field_value);
               push_rate(p.field_momentum, grad, mom, idx, 1);
            end
         end
         if (last) begin
            sweep_pos = 0;
            return;
         end
         win_phi[0] = win_phi[1]; win_phix[0] = win_phix[1];
         win_pi[0] = win_pi[1]; win_r[0] = win_r[1];
         win_phi[1] = p.field_value; win_phix[1] = p.field_gradient;
         win_pi[1] = p.field_momentum; win_r[1] = p.radius;
         sweep_pos = idx + 1;
      endfunction

      // Compares one accepted result with the oldest expected one.
      function void check_rate(rsp_type got);
         rsp_type want;
         if (expected_rates.size() == 0) begin
            errors++;
            if (errors <= 10) $display("Unexpected result %h", got);
            return;
         end
         want = expected_rates.pop_front();
         if (got.value_rate !== want.value_rate || got.gradient_rate !== want.gradient_rate ||
             got.momentum_rate !== want.momentum_rate ||
             got.point_index !== want.point_index || got.final_point !== want.final_point) begin
            errors++;
            if (errors <= 10)
               $display("Mismatch: expected %h %h %h %0d %b, actual %h %h %h %0d %b",
                        want.value_rate, want.gradient_rate, want.momentum_rate,
                        want.point_index, want.final_point, got.value_rate,
                        got.gradient_rate, got.momentum_rate, got.point_index,
                        got.final_point);
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 0;
   rsp_type rsp_data;
   logic csr_valid = 0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [DATA_W-1:0] csr_data = '0;

   rate_scoreboard rates = new();
   int send_idle_pct = 13;
   int recv_idle_pct = 80;
   int points_sent = 0;
   int idle_cycles = 0;

   wave_equation_stencil_rhs_top uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   // Result side: random stalls, and each accepted result is checked.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) rates.check_rate(rsp_data);
      rsp_ready <= reset ? 1'b0 : ($urandom_range(99) >= recv_idle_pct);
   end

   // Watchdog on cycles without any accepted item.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > STALL_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   task automatic send_point(req_type p);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= p;
      do @(posedge clock); while (!req_ready);
      rates.note_point(p);
      points_sent++;
   endtask

   task automatic write_reg(csr_index_type idx, logic [DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      rates.write_reg(idx, data);
   endtask

   // Holds off until every expected result is out and the block has settled.
   task automatic drain();
      req_valid <= 1'b0;
      while (rates.expected_rates.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [DATA_W-1:0] pick_word();
      case ($urandom_range(9))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'h0;
         3: return $urandom_range(200000) - 100000;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [KREG_W-1:0] pick_radius();
      case ($urandom_range(7))
         0: return '0;
         1: return '1;
         2: return KREG_W'({rates.mass, 1'b0});
         3: return KREG_W'($urandom_range(1 << 20));
         default: return KREG_W'($urandom);
      endcase
   endfunction

   function automatic req_type make_point(bit last);
      req_type p;
      p.field_value = pick_word();
      p.field_gradient = pick_word();
      p.field_momentum = pick_word();
      p.radius = pick_radius();
      p.last_point = last;
      return p;
   endfunction

   function automatic req_type fixed_point(logic [DATA_W-1:0] phi, logic [DATA_W-1:0] phix,
                                           logic [DATA_W-1:0] mom, logic [KREG_W-1:0] r,
                                           bit last);
      req_type p;
      p.field_value = phi;
      p.field_gradient = phix;
      p.field_momentum = mom;
      p.radius = r;
      p.last_point = last;
      return p;
   endfunction

   // Random sweep; mostly short, with the last flag on its final point.
   task automatic send_sweep();
      int len;
      len = ($urandom_range(9) == 0) ? $urandom_range(40, 2) : $urandom_range(6, 1);
      for (int i = 0; i < len; i++) send_point(make_point(i == len - 1));
   endtask

   task automatic write_all(logic [DATA_W-1:0] k0, logic [DATA_W-1:0] k1,
                            logic [DATA_W-1:0] k2, logic [DATA_W-1:0] l,
                            logic [DATA_W-1:0] m);
      write_reg(CSR_INV_SPACING, k0);
      write_reg(CSR_INV_SPACING_SQ, k1);
      write_reg(CSR_INV_TWO_SPACING, k2);
      write_reg(CSR_HARMONIC_MODE, l);
      write_reg(CSR_HOLE_MASS, m);
   endtask

   initial begin
      rates.clear();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed sweeps: single-point grids, a two-point grid, a five-point grid
      // with a horizon point, zero and widest radius, and field extremes.
      send_point(fixed_point(32'h7fff_ffff, 32'h0, 32'h8000_0000, '0, 1));
      send_point(fixed_point(32'h8000_0000, 32'h1, 32'h7fff_ffff, '1, 1));
      send_point(fixed_point(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, '0, 0));
      send_point(fixed_point(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, '1, 1));
      send_point(fixed_point(32'h0001_0000, 32'h0, 32'h0, 31'd131072, 0));
      send_point(fixed_point(32'h7fff_ffff, 32'hffff_0000, 32'h0002_0000, 31'd131072, 0));
      send_point(fixed_point(32'h8000_0000, 32'h0, 32'h7fff_ffff, 31'd1, 0));
      send_point(fixed_point(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, '0, 0));
      send_point(fixed_point(32'h0, 32'h7fff_ffff, 32'hffff_ffff, '1, 1));
      for (int i = 0; i < 5; i++) send_point(make_point(i == 4));

      for (int phase = 0; phase < 7; phase++) begin
         drain();
         case (phase)
            0: write_all(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                         32'hffff_ffff);
            1: write_all(32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
            6: write_all($urandom, $urandom, $urandom, $urandom, 32'h0001_0000);
            default: write_all($urandom_range(1 << 20), $urandom, $urandom_range(1 << 18),
                               $urandom_range(63), $urandom_range(1 << 22));
         endcase
         if (phase == 2) begin
            send_idle_pct = 80;
            recv_idle_pct = 13;
         end else if (phase == 4) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         while (points_sent < 25 + (phase + 1) * 265) send_sweep();
      end

      drain();
      if (rates.errors == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

endmodule

@@ files.f @@
rtl/core/wes_pkg.sv
rtl/core/wes_front.sv
rtl/core/wes_queue.sv
rtl/core/wes_mdu.sv
rtl/core/wes_back.sv
rtl/core/wave_equation_stencil_rhs_top.sv
dv/wave_equation_stencil_rhs_top_tb.sv
